// ===== rtl/core/cra_pkg.sv =====
// Shared types and constants of the circle rasterizer.
package cra_pkg;

   localparam int CoordW = 13;   // center coordinate width, signed
   localparam int RadW   = 10;   // radius width
   localparam int ColorW = 24;   // RGB color width
   localparam int OffW   = 11;   // scan offset width, signed, -1023..1023
   localparam int PixW   = 14;   // screen coordinate width, signed
   localparam int SqW    = 2 * RadW;   // square of a magnitude
   localparam int DistW  = SqW + 1;    // sum of two squares

   localparam int ReqDataW = 64; // 61 field bits rounded up to bytes
   localparam int RspDataW = 56; // 52 field bits rounded up to bytes

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic {
      MODE_FILLED = 1'b0,
      MODE_RING   = 1'b1
   } mode_type;

   // One scanned point, handed from the scan sequencer to the coverage test.
   typedef struct packed {
      logic [OffW-1:0]   off_x;
      logic [OffW-1:0]   off_y;
      logic [RadW-1:0]   radius;
      mode_type          mode;
      logic [PixW-1:0]   pix_x;
      logic [PixW-1:0]   pix_y;
      logic [ColorW-1:0] color;
      logic              last;
   } point_type;

   typedef struct packed {
      logic active;
      logic pt_valid;
   } scan_sts_type;

endpackage

// ===== rtl/core/cra_scan.sv =====
// Scan sequencer: held circle, offset counters and the point register.
module cra_scan
   import cra_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,     // item accepted this cycle
   input  op_type            op,
   input  logic [CoordW-1:0] center_x,
   input  logic [CoordW-1:0] center_y,
   input  logic [RadW-1:0]   radius,
   input  logic [ColorW-1:0] color,
   input  mode_type          mode,
   input  logic              pt_take,     // downstream takes the point
   output point_type         pt,
   output scan_sts_type      sts
);

   logic              active_ff, active_in;
   logic [OffW-1:0]   off_x_ff, off_x_in;
   logic [OffW-1:0]   off_y_ff, off_y_in;
   logic [CoordW-1:0] cx_ff, cx_in;
   logic [CoordW-1:0] cy_ff, cy_in;
   logic [RadW-1:0]   rad_ff, rad_in;
   logic [ColorW-1:0] color_ff, color_in;
   mode_type          mode_ff, mode_in;
   point_type         pt_ff, pt_in;
   logic              pt_v_ff, pt_v_in;

   logic [OffW-1:0]   r_ext;
   logic              row_end;
   logic              is_last;
   logic              do_start;
   logic              do_step;

   assign r_ext    = {1'b0, rad_ff};
   assign row_end  = (off_x_ff == r_ext);
   assign is_last  = row_end && (off_y_ff == r_ext);
   assign do_start = advance && (op == OP_START);
   assign do_step  = advance && (op == OP_STEP) && active_ff;

   always_comb begin
      active_in = active_ff;
      off_x_in  = off_x_ff;
      off_y_in  = off_y_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      rad_in    = rad_ff;
      color_in  = color_ff;
      mode_in   = mode_ff;

      if (do_start) begin
         cx_in     = center_x;
         cy_in     = center_y;
         rad_in    = radius;
         color_in  = color;
         mode_in   = mode;
         off_x_in  = OffW'(0) - {1'b0, radius};
         off_y_in  = OffW'(0) - {1'b0, radius};
         active_in = 1'b1;
      end else if (do_step) begin
         if (is_last) begin
            active_in = 1'b0;
         end else if (row_end) begin
            off_x_in = OffW'(0) - r_ext;
            off_y_in = off_y_ff + OffW'(1);
         end else begin
            off_x_in = off_x_ff + OffW'(1);
         end
      end

      pt_in.off_x  = off_x_ff;
      pt_in.off_y  = off_y_ff;
      pt_in.radius = rad_ff;
      pt_in.mode   = mode_ff;
      pt_in.pix_x  = {cx_ff[CoordW-1], cx_ff}
                   + {{(PixW-OffW){off_x_ff[OffW-1]}}, off_x_ff};
      pt_in.pix_y  = {cy_ff[CoordW-1], cy_ff}
                   + {{(PixW-OffW){off_y_ff[OffW-1]}}, off_y_ff};
      pt_in.color  = color_ff;
      pt_in.last   = is_last;

      if (advance) begin
         pt_v_in = do_step;
      end else if (pt_take) begin
         pt_v_in = 1'b0;
      end else begin
         pt_v_in = pt_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pt_v_ff   <= 1'b0;
         off_x_ff  <= '0;
         off_y_ff  <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         rad_ff    <= '0;
         color_ff  <= '0;
         mode_ff   <= MODE_FILLED;
      end else begin
         active_ff <= active_in;
         pt_v_ff   <= pt_v_in;
         off_x_ff  <= off_x_in;
         off_y_ff  <= off_y_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         rad_ff    <= rad_in;
         color_ff  <= color_in;
         mode_ff   <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_step) begin
         pt_ff <= pt_in;
      end
   end

   assign pt           = pt_ff;
   assign sts.active   = active_ff;
   assign sts.pt_valid = pt_v_ff;

   // The final point of the square ends the scan.
   a_last_ends_scan : assert property (@(posedge clock) disable iff (reset)
      do_step && is_last |=> !active_ff)
      else $error("scan still active after final point");

   // A start arms the scan and leaves no point behind.
   a_start_arms : assert property (@(posedge clock) disable iff (reset)
      do_start |=> active_ff && !pt_v_ff)
      else $error("start did not arm a clean scan");

endmodule

// ===== rtl/core/cra_cover.sv =====
// Coverage test: distance against radius and screen bounds for one point.
module cra_cover
   import cra_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 1024,
   parameter int SCREEN_HEIGHT = 1024
)
(
   input  point_type pt,
   output logic      write
);

   localparam logic [PixW-1:0] ScrW = PixW'(SCREEN_WIDTH);
   localparam logic [PixW-1:0] ScrH = PixW'(SCREEN_HEIGHT);

   logic [OffW-1:0]  neg_x, neg_y;
   logic [RadW-1:0]  mag_x, mag_y;
   logic [SqW-1:0]   sq_x, sq_y, sq_r;
   logic [DistW-1:0] dist2, ring_lo, ring_hi, disc_hi;
   logic             covered;
   logic             on_screen;

   always_comb begin
      neg_x   = OffW'(0) - pt.off_x;
      neg_y   = OffW'(0) - pt.off_y;
      mag_x   = pt.off_x[OffW-1] ? neg_x[RadW-1:0] : pt.off_x[RadW-1:0];
      mag_y   = pt.off_y[OffW-1] ? neg_y[RadW-1:0] : pt.off_y[RadW-1:0];
      sq_x    = mag_x * mag_x;
      sq_y    = mag_y * mag_y;
      sq_r    = pt.radius * pt.radius;
      dist2   = {1'b0, sq_x} + {1'b0, sq_y};
      disc_hi = {1'b0, sq_r};
      ring_lo = disc_hi - {{(DistW-RadW){1'b0}}, pt.radius};
      ring_hi = disc_hi + {{(DistW-RadW){1'b0}}, pt.radius};

      if (pt.mode == MODE_RING) begin
         covered = (dist2 >= ring_lo) && (dist2 <= ring_hi);
      end else begin
         covered = (dist2 <= disc_hi);
      end

      // Negative coordinates fail on the sign bit; the rest compare unsigned.
      on_screen = !pt.pix_x[PixW-1] && (pt.pix_x < ScrW)
               && !pt.pix_y[PixW-1] && (pt.pix_y < ScrH);

      write = covered && on_screen;
   end

endmodule

// ===== rtl/core/circle_rasterizer_unit.sv =====
// Throughput: one item per cycle unless rsp stalls; start items and steps with
// no active circle are accepted but give no result and leave the point stage empty.
// The offset counters and point register form stage one, coverage test and
// output register stage two; both stages advance together when rsp is free,
// and stage one also takes an item while it is empty.
// Reset (synchronous, active high) drops any active scan and empties both stages.
module circle_rasterizer_unit
   import cra_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 1024,
   parameter int SCREEN_HEIGHT = 1024
)
(
   input  logic                clock,
   input  logic                reset,

   // Item channel.
   input  logic                req_tvalid,
   output logic                req_tready,
   // [12:0] center_x, [25:13] center_y, [35:26] radius, [59:36] color,
   // [60] mode, [63:61] zero
   input  logic [ReqDataW-1:0] req_tdata,
   // [0] op: 0 start circle, 1 step one point
   input  logic                req_tuser,

   // Result channel.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [13:0] pixel_x, [27:14] pixel_y, [51:28] pixel_color, [55:52] zero
   output logic [RspDataW-1:0] rsp_tdata,
   // [0] write: point covered and on screen
   output logic                rsp_tuser,
   output logic                rsp_tlast
);

   localparam logic [PixW-1:0] ScrW = PixW'(SCREEN_WIDTH);
   localparam logic [PixW-1:0] ScrH = PixW'(SCREEN_HEIGHT);

   // Unpack the item fields.
   op_type            req_op;
   logic [CoordW-1:0] req_center_x;
   logic [CoordW-1:0] req_center_y;
   logic [RadW-1:0]   req_radius;
   logic [ColorW-1:0] req_color;
   mode_type          req_mode;

   assign req_op       = op_type'(req_tuser);
   assign req_center_x = req_tdata[12:0];
   assign req_center_y = req_tdata[25:13];
   assign req_radius   = req_tdata[35:26];
   assign req_color    = req_tdata[59:36];
   assign req_mode     = mode_type'(req_tdata[60]);

   point_type    pt;
   scan_sts_type sts;
   logic         pt_write;
   logic         out_ready;
   logic         req_fire;

   // Output stage free when empty or its item leaves this cycle.
   assign out_ready  = !rsp_tvalid || rsp_tready;
   // Point stage takes a new item when empty or its point moves on.
   assign req_tready = !sts.pt_valid || out_ready;
   assign req_fire   = req_tvalid && req_tready;

   cra_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .advance  (req_fire),
      .op       (req_op),
      .center_x (req_center_x),
      .center_y (req_center_y),
      .radius   (req_radius),
      .color    (req_color),
      .mode     (req_mode),
      .pt_take  (out_ready),
      .pt       (pt),
      .sts      (sts)
   );

   cra_cover #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_cover (
      .pt    (pt),
      .write (pt_write)
   );

   // Output register: hold while stalled, load the point stage otherwise.
   logic                out_v_ff;
   logic [RspDataW-1:0] out_data_ff;
   logic                out_write_ff;
   logic                out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_ready) begin
         out_v_ff <= sts.pt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && sts.pt_valid) begin
         out_data_ff  <= {{(RspDataW - 2*PixW - ColorW){1'b0}},
                          pt.color, pt.pix_y, pt.pix_x};
         out_write_ff <= pt_write;
         out_last_ff  <= pt.last;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_write_ff;
   assign rsp_tlast  = out_last_ff;

   // A written pixel always lands inside the screen.
   a_write_on_screen : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         !rsp_tdata[PixW-1] && (rsp_tdata[PixW-1:0] < ScrW) &&
         !rsp_tdata[2*PixW-1] && (rsp_tdata[2*PixW-1:PixW] < ScrH))
      else $error("write flag set for an off-screen pixel");

   // A point blocked by a full output stage stays put.
   a_point_holds : assert property (@(posedge clock) disable iff (reset)
      sts.pt_valid && !out_ready |=> sts.pt_valid && $stable(pt))
      else $error("stalled point lost or changed");

   // A step with no active circle yields no point.
   a_idle_step_silent : assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_op == OP_STEP) && !sts.active |=> !sts.pt_valid)
      else $error("point produced without an active circle");

endmodule

// ===== tb/tb_circle_rasterizer_unit.sv =====
// Self-checking testbench of the circle rasterizer: directed table, random scans, scoreboard.
`timescale 1ns / 1ps

module tb_circle_rasterizer_unit;
   import cra_pkg::*;

   localparam int SCREEN_W     = 1024;
   localparam int SCREEN_H     = 1024;
   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_ITEMS = 1800;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DIR_ROWS     = 26;

   // How a directed row is checked: by the predictor, as no result, or as a typed point.
   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_PIXEL
   } check_kind_type;

   typedef struct packed {
      logic [PixW-1:0]   px;
      logic [PixW-1:0]   py;
      logic [ColorW-1:0] color;
      logic              wr;
      logic              lst;
   } pixel_type;

   typedef struct packed {
      check_kind_type chk;
      pixel_type      pix;
   } typed_check_type;

   typedef struct packed {
      op_type            op;
      logic [CoordW-1:0] cx;
      logic [CoordW-1:0] cy;
      logic [RadW-1:0]   rad;
      logic [ColorW-1:0] color;
      mode_type          mode;
      check_kind_type    chk;
      pixel_type         pix;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;

   // Predictor copy of the scan state.
   logic                     scan_active = 1'b0;
   logic signed [OffW-1:0]   scan_ox     = '0;
   logic signed [OffW-1:0]   scan_oy     = '0;
   logic signed [CoordW-1:0] circ_cx     = '0;
   logic signed [CoordW-1:0] circ_cy     = '0;
   logic [RadW-1:0]          circ_r      = '0;
   logic [ColorW-1:0]        circ_color  = '0;
   mode_type                 circ_mode   = MODE_FILLED;

   pixel_type       pending_pixels [$];
   typed_check_type typed_checks [$];
   int              mismatches;
   int              cycle_count;
   int              items_sent;
   int              stall_left;
   bit              calm;

   // Directed table: extremes of every field, zero radius, off-screen points,
   // a step with no circle, a scan that runs out and a start that drops a scan.
   dir_row_type dir_rows [DIR_ROWS] = '{
      // step right after reset: nothing active, all other fields ignored
      '{OP_STEP, 13'h1FFF, 13'h1FFF, 10'h3FF, 24'hFFFFFF, MODE_RING, CHK_NONE, '0},
      // zero radius, filled: single covered point that is also last
      '{OP_START, 13'd5, 13'd7, 10'd0, 24'hFFFFFF, MODE_FILLED, CHK_NONE, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_PIXEL,
        '{14'd5, 14'd7, 24'hFFFFFF, 1'b1, 1'b1}},
      // scan is over: step gives nothing
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_NONE, '0},
      // zero radius ring at the screen origin
      '{OP_START, 13'd0, 13'd0, 10'd0, 24'h000000, MODE_RING, CHK_NONE, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_PIXEL,
        '{14'd0, 14'd0, 24'h000000, 1'b1, 1'b1}},
      // largest center: covered but off screen
      '{OP_START, 13'h0FFF, 13'h0FFF, 10'd0, 24'h123456, MODE_RING, CHK_NONE, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_PIXEL,
        '{14'h0FFF, 14'h0FFF, 24'h123456, 1'b0, 1'b1}},
      // most negative center
      '{OP_START, 13'h1000, 13'd1023, 10'd2, 24'h00AA55, MODE_RING, CHK_NONE, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_PIXEL,
        '{14'h2FFE, 14'd1021, 24'h00AA55, 1'b0, 1'b0}},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_MODEL, '0},
      // full ring of radius one on the right screen edge
      '{OP_START, 13'd1023, 13'd0, 10'd1, 24'hABCDEF, MODE_RING, CHK_NONE, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_MODEL, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_MODEL, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_MODEL, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_MODEL, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_MODEL, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_MODEL, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_MODEL, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_MODEL, '0},
      '{OP_STEP, 13'h0AAA, 13'h1555, 10'h155, 24'h5A5A5A, MODE_RING, CHK_MODEL, '0},
      // largest radius: first corner, then dropped by the next start
      '{OP_START, 13'd0, 13'd0, 10'd1023, 24'h00FF00, MODE_FILLED, CHK_NONE, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_PIXEL,
        '{14'h3C01, 14'h3C01, 24'h00FF00, 1'b0, 1'b0}},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_MODEL, '0},
      '{OP_START, 13'd512, 13'd512, 10'd3, 24'h5A5A5A, MODE_FILLED, CHK_NONE, '0},
      '{OP_STEP, '0, '0, '0, '0, MODE_FILLED, CHK_MODEL, '0}
   };

   circle_rasterizer_unit #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Advance the predicted scan by one item; emits is set when a point comes out.
   task automatic rasterize_item(input op_type op, input logic [ReqDataW-1:0] d,
                                 output bit emits, output pixel_type p);
      int r;
      int d2;
      int r2;
      logic signed [PixW-1:0] px;
      logic signed [PixW-1:0] py;
      bit covered;
      bit on_screen;
      bit is_last;
      emits = 1'b0;
      p     = '0;
      if (op == OP_START) begin
         circ_cx     = d[12:0];
         circ_cy     = d[25:13];
         circ_r      = d[35:26];
         circ_color  = d[59:36];
         circ_mode   = mode_type'(d[60]);
         scan_ox     = -$signed({1'b0, circ_r});
         scan_oy     = -$signed({1'b0, circ_r});
         scan_active = 1'b1;
      end else if (scan_active) begin
         r  = int'(circ_r);
         d2 = int'(scan_ox) * int'(scan_ox) + int'(scan_oy) * int'(scan_oy);
         r2 = r * r;
         if (circ_mode == MODE_FILLED)
            covered = d2 <= r2;
         else
            covered = d2 >= r2 - r && d2 <= r2 + r;
         px        = circ_cx + scan_ox;
         py        = circ_cy + scan_oy;
         on_screen = px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H;
         is_last   = int'(scan_ox) == r && int'(scan_oy) == r;
         p     = '{px, py, circ_color, covered && on_screen, is_last};
         emits = 1'b1;
         if (is_last) begin
            scan_active = 1'b0;
         end else if (int'(scan_ox) == r) begin
            scan_ox = -$signed({1'b0, circ_r});
            scan_oy = scan_oy + 1;
         end else begin
            scan_ox = scan_ox + 1;
         end
      end
   endtask

   function automatic logic [ReqDataW-1:0] pack_req(logic [CoordW-1:0] cx,
         logic [CoordW-1:0] cy, logic [RadW-1:0] rad, logic [ColorW-1:0] color,
         logic mode);
      return {3'b000, mode, color, rad, cy, cx};
   endfunction

   // Mostly short gaps, a few long ones; none during calm stretches.
   function automatic int pick_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 2);
      else if (roll < 97)
         return $urandom_range(3, 8);
      else
         return $urandom_range(20, 40);
   endfunction

   // Offer one item after a random gap and hold it until accepted.
   task automatic send_item(input op_type op, input logic [ReqDataW-1:0] d,
                            input typed_check_type tc);
      int gap;
      gap = pick_pause();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_checks.push_back(tc);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Drop valid and hold off until every predicted point has come out.
   task automatic wait_for_pixels();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int exp, input int act);
      if (exp != act) begin
         $error("%s: expected %0d, got %0d", name, exp, act);
         mismatches++;
      end
   endtask

   // Predict at each accepted request item.
   always @(posedge clock) begin
      bit              emits;
      pixel_type       p;
      typed_check_type tc;
      if (!reset && req_tvalid && req_tready) begin
         rasterize_item(op_type'(req_tuser), req_tdata, emits, p);
         tc = typed_checks.pop_front();
         if (tc.chk == CHK_PIXEL)
            pending_pixels.push_back(tc.pix);
         else if (tc.chk == CHK_MODEL && emits)
            pending_pixels.push_back(p);
      end
   end

   // Compare each accepted result item with the oldest predicted point.
   always @(posedge clock) begin
      pixel_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected point x=%0d y=%0d", $signed(rsp_tdata[13:0]),
                   $signed(rsp_tdata[27:14]));
            mismatches++;
         end else begin
            e = pending_pixels.pop_front();
            check_field("pixel_x", $signed(e.px), $signed(rsp_tdata[13:0]));
            check_field("pixel_y", $signed(e.py), $signed(rsp_tdata[27:14]));
            check_field("pixel_color", e.color, rsp_tdata[51:28]);
            check_field("write", e.wr, rsp_tuser);
            check_field("last", e.lst, rsp_tlast);
         end
      end
   end

   // Receiver: random stalls, with calm stretches of full throughput.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 25)
            stall_left <= pick_pause();
      end
   end

   // Watchdog and calm-stretch phase.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      calm        <= (cycle_count % 3000) < 600;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      typed_check_type     model_chk;
      int                  seq;
      int                  roll;
      int                  n;
      int                  r;
      int                  cx;
      int                  cy;
      int                  full;
      logic [ReqDataW-1:0] junk;
      model_chk   = '{CHK_MODEL, '0};
      items_sent  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_START;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table.
      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].op,
                   pack_req(dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].rad,
                            dir_rows[i].color, dir_rows[i].mode),
                   '{dir_rows[i].chk, dir_rows[i].pix});
      end
      wait_for_pixels();

      // Random scans: mostly whole squares, some cut short, some stray steps.
      items_sent = 0;
      seq        = 0;
      while (items_sent < RANDOM_ITEMS) begin
         seq++;
         if (seq % 8 == 0)
            wait_for_pixels();
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            n = $urandom_range(1, 5);
            repeat (n) begin
               junk = {$urandom(), $urandom()};
               send_item(OP_STEP, junk, model_chk);
            end
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
               r = $urandom_range(0, 3);
            else if (roll < 97)
               r = $urandom_range(4, 8);
            else
               r = 1023;
            case ($urandom_range(0, 2))
               0: begin
                  cx = ($urandom_range(0, 1) ? SCREEN_W - 1 : 0)
                       + $urandom_range(0, 2 * r + 2) - (r + 1);
                  cy = ($urandom_range(0, 1) ? SCREEN_H - 1 : 0)
                       + $urandom_range(0, 2 * r + 2) - (r + 1);
               end
               1: begin
                  cx = $urandom_range(0, SCREEN_W - 1);
                  cy = $urandom_range(0, SCREEN_H - 1);
               end
               default: begin
                  cx = $urandom_range(0, 8191) - 4096;
                  cy = $urandom_range(0, 8191) - 4096;
               end
            endcase
            send_item(OP_START,
                      pack_req(cx[12:0], cy[12:0], r[9:0], ColorW'($urandom()),
                               1'($urandom_range(0, 1))),
                      model_chk);
            full = (2 * r + 1) * (2 * r + 1);
            if (r == 1023)
               n = $urandom_range(20, 80);
            else if ($urandom_range(0, 99) < 80)
               n = full + $urandom_range(0, 2);
            else
               n = $urandom_range(0, full);
            repeat (n) begin
               junk = {$urandom(), $urandom()};
               send_item(OP_STEP, junk, model_chk);
            end
         end
      end

      // Drain, then let the pipeline settle before the verdict.
      wait_for_pixels();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_pixels.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/cra_pkg.sv
rtl/core/cra_scan.sv
rtl/core/cra_cover.sv
rtl/core/circle_rasterizer_unit.sv
tb/tb_circle_rasterizer_unit.sv
